FILE: src/ndom_pkg.sv
// shared types and constants for the nested dissection owner map
package ndom_pkg;

   localparam int COORD_W = 12;
   localparam int DIM_W   = 13;
   localparam int Z_W     = 8;
   localparam int RANK_W  = 10;
   localparam int DEPTH_REG_W = 4;
   localparam int PROD_W  = Z_W + DIM_W;
   localparam int SUM_W   = PROD_W + 1;

   localparam logic [DIM_W-1:0]       WIDTH_RESET  = DIM_W'(64);
   localparam logic [DIM_W-1:0]       HEIGHT_RESET = DIM_W'(64);
   localparam logic [DEPTH_REG_W-1:0] DEPTH_RESET  = '0;

   localparam logic [1:0] CSR_PLANE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_PLANE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_SPLIT_DEPTH  = 2'd2;

   // remaining sub-rectangle and the point inside it
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [DIM_W-1:0]   xs;
      logic [DIM_W-1:0]   ys;
      logic [Z_W-1:0]     z;
   } geom_type;

   // per-word status that travels down the chain
   typedef struct packed {
      logic              valid;
      logic              oor;
      logic              hit;
      logic [RANK_W-1:0] rank;
   } stat_type;

endpackage

FILE: src/ndom_cell.sv
// one bisection level of the owner map chain
module ndom_cell #(
   parameter int LEVEL     = 0,
   parameter int DEPTH_W   = 4,
   parameter int VAL_W     = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  ndom_pkg::geom_type  geom_i,
   input  ndom_pkg::stat_type  stat_i,
   input  logic [DEPTH_W-1:0]  depth_i,
   input  logic [VAL_W-1:0]    sep_i,
   output ndom_pkg::geom_type  geom_o,
   output ndom_pkg::stat_type  stat_o,
   output logic [DEPTH_W-1:0]  depth_o,
   output logic [VAL_W-1:0]    sep_o
);
   import ndom_pkg::*;

   geom_type           geom_ff, geom_in;
   stat_type           stat_ff, stat_in;
   logic [DEPTH_W-1:0] depth_ff;
   logic [VAL_W-1:0]   sep_ff, sep_in;

   logic               active;
   logic               xcut;
   logic [DIM_W-1:0]   side;
   logic [DIM_W-1:0]   len;
   logic [COORD_W-1:0] coord;
   logic [COORD_W-1:0] idx;
   logic [DIM_W-1:0]   left;
   logic [PROD_W-1:0]  prod;
   logic [SUM_W-1:0]   sum;
   logic [VAL_W-1:0]   sep_val;
   logic [DEPTH_W-1:0] bit_sel;
   logic [VAL_W-1:0]   sep_shift;
   logic               new_bit;

   always_comb begin
      active  = stat_i.valid && !stat_i.oor && (LEVEL < int'(depth_i));
      xcut    = (geom_i.xs >= geom_i.ys);
      side    = xcut ? geom_i.xs : geom_i.ys;
      len     = xcut ? geom_i.ys : geom_i.xs;
      coord   = xcut ? geom_i.x : geom_i.y;
      idx     = xcut ? geom_i.y : geom_i.x;
      left    = (side - DIM_W'(1)) >> 1;
      prod    = PROD_W'(geom_i.z) * PROD_W'(len);
      sum     = SUM_W'(prod) + SUM_W'(idx);
      // bit of the separator value that this level contributes
      bit_sel = DEPTH_W'(int'(depth_i) - LEVEL - 1);

      geom_in = geom_i;
      stat_in = stat_i;
      sep_in  = sep_i;
      sep_val = sep_i;

      if (active && !stat_i.hit && (DIM_W'(coord) == left)) begin
         sep_val    = VAL_W'(sum);
         sep_in     = sep_val;
         stat_in.hit = 1'b1;
      end

      sep_shift = sep_val >> bit_sel;

      if (active) begin
         if (stat_i.hit || (DIM_W'(coord) == left)) begin
            new_bit = sep_shift[0];
         end else if (DIM_W'(coord) > left) begin
            new_bit = 1'b1;
            if (xcut) begin
               geom_in.x  = geom_i.x - COORD_W'(left + DIM_W'(1));
               geom_in.xs = geom_i.xs - (left + DIM_W'(1));
            end else begin
               geom_in.y  = geom_i.y - COORD_W'(left + DIM_W'(1));
               geom_in.ys = geom_i.ys - (left + DIM_W'(1));
            end
         end else begin
            new_bit = 1'b0;
            if (xcut) begin
               geom_in.xs = left;
            end else begin
               geom_in.ys = left;
            end
         end
         stat_in.rank = {stat_i.rank[RANK_W-2:0], new_bit};
      end else begin
         new_bit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff.valid <= 1'b0;
      end else if (advance) begin
         stat_ff.valid <= stat_in.valid;
      end
      if (advance) begin
         geom_ff      <= geom_in;
         stat_ff.oor  <= stat_in.oor;
         stat_ff.hit  <= stat_in.hit;
         stat_ff.rank <= stat_in.rank;
         depth_ff     <= depth_i;
         sep_ff       <= sep_in;
      end
   end

   assign geom_o  = geom_ff;
   assign stat_o  = stat_ff;
   assign depth_o = depth_ff;
   assign sep_o   = sep_ff;

endmodule

FILE: src/nested_dissection_owner_map.sv
// top level: owner rank of a grid point under nested dissection
// an accepted req word passes through the MAX_DEPTH level cell registers to rsp_valid
// throughput: one word per cycle while no rsp word is held, set by the chain of MAX_DEPTH level cells
// a stalled rsp word freezes the whole chain, req_stall follows at once
// reset (synchronous, active high) empties the chain and loads
// width 64, height 64, split depth 0
module nested_dissection_owner_map #(
   parameter int MAX_DEPTH = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ndom_pkg::COORD_W-1:0]      req_point_x,
   input  logic [ndom_pkg::COORD_W-1:0]      req_point_y,
   input  logic [ndom_pkg::Z_W-1:0]          req_z_local,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ndom_pkg::RANK_W-1:0]       rsp_owner_rank,
   output logic                              rsp_out_of_range,
   // configuration writes
   input  logic                              csr_wr_en,
   input  logic [1:0]                        csr_index,
   input  logic [ndom_pkg::DIM_W-1:0]        csr_data
);
   import ndom_pkg::*;

   // stored depth must hold MAX_DEPTH itself
   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
   // only the low remaining-depth bits of a separator value ever matter
   localparam int VAL_W   = MAX_DEPTH;

   logic [DIM_W-1:0]       width_ff;
   logic [DIM_W-1:0]       height_ff;
   logic [DEPTH_REG_W-1:0] depth_reg_ff;

   logic                   advance;
   logic [DEPTH_W-1:0]     depth_eff;

   geom_type               geom_chain  [MAX_DEPTH+1];
   stat_type               stat_chain  [MAX_DEPTH+1];
   logic [DEPTH_W-1:0]     depth_chain [MAX_DEPTH+1];
   logic [VAL_W-1:0]       sep_chain   [MAX_DEPTH+1];

   // configuration registers, unknown index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         depth_reg_ff <= DEPTH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PLANE_WIDTH:  width_ff     <= csr_data;
            CSR_PLANE_HEIGHT: height_ff    <= csr_data;
            CSR_SPLIT_DEPTH:  depth_reg_ff <= csr_data[DEPTH_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // the whole chain moves unless the finished word is held
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // depths beyond the chain length saturate
   assign depth_eff = (int'(depth_reg_ff) > MAX_DEPTH) ? DEPTH_W'(MAX_DEPTH)
                                                       : DEPTH_W'(depth_reg_ff);

   // head of the chain: full plane, empty rank, range check
   always_comb begin
      geom_chain[0].x     = req_point_x;
      geom_chain[0].y     = req_point_y;
      geom_chain[0].xs    = width_ff;
      geom_chain[0].ys    = height_ff;
      geom_chain[0].z     = req_z_local;
      stat_chain[0].valid = req_valid;
      stat_chain[0].oor   = (DIM_W'(req_point_x) >= width_ff) ||
                            (DIM_W'(req_point_y) >= height_ff);
      stat_chain[0].hit   = 1'b0;
      stat_chain[0].rank  = '0;
      depth_chain[0]      = depth_eff;
      sep_chain[0]        = '0;
   end

   // one cell per bisection level
   for (genvar lv = 0; lv < MAX_DEPTH; lv++) begin : g_level
      ndom_cell #(
         .LEVEL   (lv),
         .DEPTH_W (DEPTH_W),
         .VAL_W   (VAL_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .geom_i  (geom_chain[lv]),
         .stat_i  (stat_chain[lv]),
         .depth_i (depth_chain[lv]),
         .sep_i   (sep_chain[lv]),
         .geom_o  (geom_chain[lv+1]),
         .stat_o  (stat_chain[lv+1]),
         .depth_o (depth_chain[lv+1]),
         .sep_o   (sep_chain[lv+1])
      );
   end

   // last cell's register is the output register
   assign rsp_valid        = stat_chain[MAX_DEPTH].valid;
   assign rsp_out_of_range = stat_chain[MAX_DEPTH].oor;
   // an out-of-range word never appends bits, so its rank stays zero
   assign rsp_owner_rank   = stat_chain[MAX_DEPTH].rank;

endmodule

FILE: src/ndom_checker.sv
// port-level checks for the owner map, bound to the top level
module ndom_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [ndom_pkg::RANK_W-1:0]  rsp_owner_rank,
   input logic                         rsp_out_of_range
);
   import ndom_pkg::*;

   // out-of-range words carry rank zero
   a_oor_rank_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_owner_rank == '0))
      else $error("out-of-range word with nonzero rank");

   // req side stalls exactly when the finished word is held
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall does not follow held rsp word");

   // held rsp word keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_owner_rank) && $stable(rsp_out_of_range)))
      else $error("held rsp word changed");

   // reset empties the chain
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind nested_dissection_owner_map ndom_checker u_ndom_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_owner_rank   (rsp_owner_rank),
   .rsp_out_of_range (rsp_out_of_range)
);
